### hw/rtl/assert_macros.svh
// Assertion macros used by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("never failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

### hw/rtl/dfpc_pkg.sv
// Shared constants and types of the double/fixed converter.
package dfpc_pkg;
	localparam int unsigned WordW = 32;
	localparam int unsigned FbW = 5;
	localparam logic [FbW-1:0] FracBitsReset = 5'd24;
	localparam int unsigned MantW = 52;
	localparam int unsigned ExpW = 11;
	localparam logic [ExpW-1:0] ExpBias = 11'd1023;
	localparam logic [ExpW-1:0] ExpMax = 11'h7FF;
	localparam logic MODE_TO_FIXED = 1'b0;
	localparam logic MODE_TO_DOUBLE = 1'b1;

	typedef struct packed {
		logic mode;
		logic [63:0] value_bits;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_bits;
		logic range_error;
	} out_item_t;
endpackage

### hw/rtl/dfpc_if.sv
// Valid/ready channel carrying one payload.
interface dfpc_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/double_fixed_point_converter.sv
// Four-stage pipeline: one item per cycle while the output is not stalled.
// Double <-> fixed converter. Takes one item every cycle unless stalled. An item is
// registered through stages 1 to 4 in turn, and its result sits in the last stage
// until taken. A stall at the output freezes all stages together. While the last stage
// holds an item that is not taken, intake stops, even if earlier stages hold bubbles.
// frac_bits is written through cfg_we/cfg_data and must be changed only
// while the pipeline is empty.
`include "assert_macros.svh"
module double_fixed_point_converter (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [dfpc_pkg::FbW-1:0] cfg_data,
	dfpc_if.sink in_ch,
	dfpc_if.source out_ch
);
	logic [dfpc_pkg::FbW-1:0] frac_bits_q;
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv;

	// stall only when the last stage holds an item that is not taken
	assign adv = !v_s4 || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) frac_bits_q <= dfpc_pkg::FracBitsReset;
		else if (cfg_we) frac_bits_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	// ---- stage 1: decode
	logic mode_s1, neg_s1, spec_s1, zero_s1;
	logic signed [12:0] p_s1;
	logic [51:0] frac_s1;
	logic [31:0] mag_s1;
	logic [63:0] vin;
	logic [31:0] w_in;
	always_comb begin
		vin = in_ch.data.value_bits;
		w_in = vin[31:0];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= in_ch.data.mode;
			frac_s1 <= vin[51:0];
			spec_s1 <= vin[62:52] == dfpc_pkg::ExpMax;
			zero_s1 <= vin[62:52] == '0;
			p_s1 <= $signed({2'b00, vin[62:52]}) - $signed({2'b00, dfpc_pkg::ExpBias})
				+ $signed({8'd0, frac_bits_q});
			if (in_ch.data.mode == dfpc_pkg::MODE_TO_DOUBLE) begin
				neg_s1 <= w_in[31];
				mag_s1 <= w_in[31] ? (32'd0 - w_in) : w_in;
			end else begin
				neg_s1 <= vin[63];
				mag_s1 <= '0;
			end
		end
	end

	// ---- stage 2: range check / leading one search
	logic mode_s2, neg_s2, err_s2, zres_s2, mz_s2;
	logic [4:0] sh_s2, top_s2;
	logic [52:0] mant_s2;
	logic [31:0] mag_s2;
	logic [4:0] top_c;
	always_comb begin
		top_c = '0;
		for (int i = 0; i < 32; i++) if (mag_s1[i]) top_c = 5'(i);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2 <= mode_s1;
			neg_s2 <= neg_s1;
			mag_s2 <= mag_s1;
			top_s2 <= top_c;
			mz_s2 <= mag_s1 == '0;
			mant_s2 <= {1'b1, frac_s1};
			err_s2 <= spec_s1 || (!zero_s1 && (p_s1 >= 13'sd32 ||
				(p_s1 == 13'sd31 && (!neg_s1 || frac_s1 != '0))));
			zres_s2 <= zero_s1 || p_s1 < 13'sd0;
			sh_s2 <= p_s1[4:0];
		end
	end

	// ---- stage 3: shift
	logic mode_s3, neg_s3, err_s3, zres_s3, mz_s3;
	logic [31:0] fmag_s3;
	logic [51:0] dmant_s3;
	logic [10:0] dexp_s3;
	logic [83:0] dsh;
	always_comb dsh = {52'd0, mag_s2} << (6'd52 - {1'b0, top_s2});
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s3 <= mode_s2;
			neg_s3 <= neg_s2;
			err_s3 <= err_s2;
			zres_s3 <= zres_s2;
			mz_s3 <= mz_s2;
			fmag_s3 <= 32'(mant_s2 >> (6'd52 - {1'b0, sh_s2}));
			dmant_s3 <= dsh[51:0];
			dexp_s3 <= 11'({6'd0, top_s2}) - 11'({6'd0, frac_bits_q}) + dfpc_pkg::ExpBias;
		end
	end

	// ---- stage 4: assemble
	dfpc_pkg::out_item_t res_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			if (mode_s3 == dfpc_pkg::MODE_TO_DOUBLE) begin
				res_s4.range_error <= 1'b0;
				res_s4.result_bits <= mz_s3 ? 64'd0 : {neg_s3, dexp_s3, dmant_s3};
			end else if (err_s3) begin
				res_s4.range_error <= 1'b1;
				res_s4.result_bits <= 64'd1;
			end else begin
				res_s4.range_error <= 1'b0;
				res_s4.result_bits <= zres_s3 ? 64'd0 :
					{32'd0, neg_s3 ? (32'd0 - fmag_s3) : fmag_s3};
			end
		end
	end
	assign out_ch.valid = v_s4;
	assign out_ch.data = res_s4;

	`ASSERT_CLK(a_hold, clk, arst_n, (v_s4 && !out_ch.ready) |=> (v_s4 && $stable(res_s4)))
	`ASSERT_CLK(a_mode1_noerr, clk, arst_n,
		(v_s4 && mode_s3 == dfpc_pkg::MODE_TO_DOUBLE && adv && v_s3) |=> !res_s4.range_error)
	`ASSERT_NEVER(a_err_val, clk, arst_n, v_s4 && res_s4.range_error && res_s4.result_bits != 64'd1)
endmodule
